### rtl/open_file_lock_table_unit_macros.svh
// Assertion macros shared by the lock table RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef OPEN_FILE_LOCK_TABLE_UNIT_MACROS_SVH
`define OPEN_FILE_LOCK_TABLE_UNIT_MACROS_SVH

// clocked assertion with an explicit clock and reset
`define OFLT_ASSERT_CLK(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// usual form: clk and rst of the enclosing module
`define OFLT_ASSERT(lbl, prop, msg) \
  `OFLT_ASSERT_CLK(lbl, clk, rst, prop, msg)

`endif

### rtl/oflt_pkg.sv
// Types and fixed codes of the open file lock table.
// No dependencies; used by every RTL file of the block.
package oflt_pkg;

  localparam logic [2:0] CMD_CHECK   = 3'd0;
  localparam logic [2:0] CMD_ENQUIRE = 3'd1;
  localparam logic [2:0] CMD_OPEN    = 3'd2;
  localparam logic [2:0] CMD_CLOSE   = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  localparam logic [1:0] ACC_READ    = 2'd0;
  localparam logic [1:0] ACC_DELETE  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_LOCKED   = 3'd1;
  localparam logic [2:0] ST_TOO_MANY = 3'd2;
  localparam logic [2:0] ST_ERROR    = 3'd3;
  localparam logic [2:0] ST_INT_ERR  = 3'd4;

  localparam logic [8:0] WRITE_MARK  = 9'h100;
  localparam logic [8:0] READ_MAX    = 9'h0FF;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  volume_id;
    logic [31:0] dir_cluster;
    logic [31:0] dir_offset;
    logic [1:0]  access;
    logic [3:0]  close_id;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] lock_id;
  } res_t;

  typedef struct packed {
    logic [3:0]  volume;
    logic [31:0] cluster;
    logic [31:0] offset;
    logic [8:0]  count;
  } entry_t;

endpackage

### rtl/open_file_lock_table_unit.sv
// Top level of the open file lock table: sequencer, entry store, output register.
// Depends on oflt_pkg, oflt_ctrl and oflt_entry_ram.
//
//   channel | signals                                          | dir
//   --------+--------------------------------------------------+-----
//   in      | in_valid/in_ready, cmd volume_id dir_cluster     | in
//           | dir_offset access close_id                       |
//   out     | out_valid/out_ready, status lock_id              | out
//
// check, enquire, open and clear scan the entry store one entry a cycle
// through its read port. close reads and writes back one entry; a bad close
// id or an unknown command answers straight from idle. Reset clears valid
// bits and control only; the store needs no clearing pass. A word waits in
// the output register while the next command runs; the sequencer holds only
// its own result.
module open_file_lock_table_unit #(
  parameter int ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [3:0]  volume_id,
  input  logic [31:0] dir_cluster,
  input  logic [31:0] dir_offset,
  input  logic [1:0]  access,
  input  logic [3:0]  close_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [3:0]  lock_id
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  oflt_pkg::req_t   req;
  oflt_pkg::res_t   res;
  logic             res_valid;
  logic             res_ready;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  oflt_pkg::entry_t mem_rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  oflt_pkg::entry_t mem_wdata;

  assign req = '{cmd: cmd, volume_id: volume_id, dir_cluster: dir_cluster,
                 dir_offset: dir_offset, access: access, close_id: close_id};

  oflt_ctrl #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_in    (req),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  oflt_entry_ram #(
    .DEPTH (ENTRIES),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
      status    <= res.status;
      lock_id   <= res.lock_id;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### rtl/oflt_entry_ram.sv
// Entry store of the lock table: one write port, one registered read port.
// Depends on oflt_pkg for the entry layout.
module oflt_entry_ram #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_W-1:0]     waddr,
  input  oflt_pkg::entry_t     wdata,
  input  logic                 re,
  input  logic [IDX_W-1:0]     raddr,
  output oflt_pkg::entry_t     rdata
);

  oflt_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/oflt_ctrl.sv
// Command sequencer: scans the entry store, keeps valid bits, writes back.
// Depends on oflt_pkg and open_file_lock_table_unit_macros.svh.
`include "open_file_lock_table_unit_macros.svh"

module oflt_ctrl #(
  parameter int ENTRIES = 8,
  parameter int IDX_W   = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  oflt_pkg::req_t     req_in,
  input  logic               req_valid,
  output logic               req_ready,
  output oflt_pkg::res_t     res,
  output logic               res_valid,
  input  logic               res_ready,
  output logic               mem_re,
  output logic [IDX_W-1:0]   mem_raddr,
  input  oflt_pkg::entry_t   mem_rdata,
  output logic               mem_we,
  output logic [IDX_W-1:0]   mem_waddr,
  output oflt_pkg::entry_t   mem_wdata
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_CLOSE_RD = 3'd2;
  localparam logic [2:0] S_UPDATE   = 3'd3;
  localparam logic [2:0] S_RESULT   = 3'd4;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);
  localparam int CW = (IDX_W > 4) ? IDX_W : 4;

  logic [2:0]         state;
  oflt_pkg::req_t     req;
  logic [ENTRIES-1:0] valid;
  logic [IDX_W-1:0]   scan_idx;
  logic               scan_done;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [8:0]         hit_count;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic               any_cleared;
  logic [IDX_W-1:0]   close_idx;
  oflt_pkg::res_t     res_reg;

  // close id decode on the incoming word
  logic [CW-1:0]      cid_ext;
  logic [IDX_W-1:0]   cid_idx;
  logic               close_bad;

  // compare stage of the scan
  logic               vol_eq;
  logic               key_eq;

  // update step
  logic               upd_we;
  logic [IDX_W-1:0]   upd_idx;
  oflt_pkg::entry_t   upd_data;
  logic               upd_set;
  logic               upd_clr;
  oflt_pkg::res_t     upd_res;
  logic [IDX_W-1:0]   tgt_idx;
  logic [8:0]         cur_count;
  logic [8:0]         new_count;
  logic [IDX_W:0]     lid_wide;

  assign cid_ext   = CW'(req_in.close_id) - CW'(1);
  assign cid_idx   = cid_ext[IDX_W-1:0];
  assign close_bad = (req_in.close_id == 4'd0) || (int'(req_in.close_id) > ENTRIES) ||
                     !valid[cid_idx];

  assign vol_eq = (mem_rdata.volume == req.volume_id);
  assign key_eq = valid[rd_idx] && vol_eq && (mem_rdata.cluster == req.dir_cluster) &&
                  (mem_rdata.offset == req.dir_offset);

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_RESULT);
  assign res       = res_reg;

  assign mem_re    = ((state == S_SCAN) && !scan_done) || (state == S_CLOSE_RD);
  assign mem_raddr = (state == S_CLOSE_RD) ? close_idx : scan_idx;
  assign mem_we    = (state == S_UPDATE) && upd_we;
  assign mem_waddr = upd_idx;
  assign mem_wdata = upd_data;

  always_comb begin
    upd_we    = 1'b0;
    upd_idx   = close_idx;
    upd_data  = mem_rdata;
    upd_set   = 1'b0;
    upd_clr   = 1'b0;
    upd_res   = '{status: oflt_pkg::ST_ERROR, lock_id: 4'd0};
    tgt_idx   = hit ? hit_idx : free_idx;
    cur_count = hit ? hit_count : 9'd0;
    new_count = cur_count;
    lid_wide  = {1'b0, tgt_idx} + {{IDX_W{1'b0}}, 1'b1};
    unique case (req.cmd)
      oflt_pkg::CMD_CHECK: begin
        if (hit) begin
          upd_res.status = ((req.access != oflt_pkg::ACC_READ) ||
                            (hit_count == oflt_pkg::WRITE_MARK)) ?
                           oflt_pkg::ST_LOCKED : oflt_pkg::ST_OK;
        end else begin
          upd_res.status = (!free_found && (req.access != oflt_pkg::ACC_DELETE)) ?
                           oflt_pkg::ST_TOO_MANY : oflt_pkg::ST_OK;
        end
      end
      oflt_pkg::CMD_ENQUIRE: begin
        upd_res.status = free_found ? oflt_pkg::ST_OK : oflt_pkg::ST_LOCKED;
      end
      oflt_pkg::CMD_OPEN: begin
        upd_idx = tgt_idx;
        if (hit || free_found) begin
          if (req.access != oflt_pkg::ACC_READ) begin
            if (cur_count == 9'd0) begin
              new_count = oflt_pkg::WRITE_MARK;
              upd_we    = 1'b1;
            end
          end else if (cur_count < oflt_pkg::READ_MAX) begin
            new_count = cur_count + 9'd1;
            upd_we    = 1'b1;
          end
        end
        upd_data = '{volume: req.volume_id, cluster: req.dir_cluster,
                     offset: req.dir_offset, count: new_count};
        if (upd_we) begin
          upd_set = 1'b1;
          upd_res = '{status: oflt_pkg::ST_OK, lock_id: 4'(lid_wide)};
        end
      end
      oflt_pkg::CMD_CLOSE: begin
        // write-open ends outright, a read open drops by one
        new_count = (mem_rdata.count == oflt_pkg::WRITE_MARK) ? 9'd0 : mem_rdata.count;
        if (new_count != 9'd0) begin
          new_count = new_count - 9'd1;
        end
        upd_we         = 1'b1;
        upd_data.count = new_count;
        upd_clr        = (new_count == 9'd0);
        upd_res.status = oflt_pkg::ST_OK;
      end
      oflt_pkg::CMD_CLEAR: begin
        upd_res.status = any_cleared ? oflt_pkg::ST_OK : oflt_pkg::ST_INT_ERR;
      end
      default: begin
        upd_res.status = oflt_pkg::ST_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      rd_vld    <= 1'b0;
      scan_done <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req         <= req_in;
            scan_idx    <= '0;
            scan_done   <= 1'b0;
            rd_vld      <= 1'b0;
            hit         <= 1'b0;
            free_found  <= 1'b0;
            any_cleared <= 1'b0;
            close_idx   <= cid_idx;
            // a bad close id answers straight from here; a good one is replaced in update
            res_reg     <= '{status: (req_in.cmd == oflt_pkg::CMD_CLOSE) ?
                                     oflt_pkg::ST_INT_ERR : oflt_pkg::ST_ERROR,
                             lock_id: 4'd0};
            unique case (req_in.cmd)
              oflt_pkg::CMD_CHECK, oflt_pkg::CMD_ENQUIRE,
              oflt_pkg::CMD_OPEN, oflt_pkg::CMD_CLEAR: begin
                state <= S_SCAN;
              end
              oflt_pkg::CMD_CLOSE: begin
                if (close_bad) begin
                  state <= S_RESULT;
                end else begin
                  state <= S_CLOSE_RD;
                end
              end
              default: begin
                state <= S_RESULT;
              end
            endcase
          end
        end
        S_SCAN: begin
          // issue one read a cycle, compare the word read the cycle before
          if (!scan_done) begin
            rd_vld <= 1'b1;
            rd_idx <= scan_idx;
            if (scan_idx == LAST) begin
              scan_done <= 1'b1;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end else begin
            rd_vld <= 1'b0;
          end
          if (rd_vld) begin
            if (key_eq && !hit) begin
              hit       <= 1'b1;
              hit_idx   <= rd_idx;
              hit_count <= mem_rdata.count;
            end
            if (!valid[rd_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
            if ((req.cmd == oflt_pkg::CMD_CLEAR) && valid[rd_idx] && vol_eq) begin
              valid[rd_idx] <= 1'b0;
              any_cleared   <= 1'b1;
            end
            if (rd_idx == LAST) begin
              state <= S_UPDATE;
            end
          end
        end
        S_CLOSE_RD: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (upd_set) begin
            valid[upd_idx] <= 1'b1;
          end
          if (upd_clr) begin
            valid[upd_idx] <= 1'b0;
          end
          res_reg <= upd_res;
          state   <= S_RESULT;
        end
        S_RESULT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `OFLT_ASSERT(a_we_only_in_update, mem_we |-> (state == S_UPDATE), "store written outside update")
  `OFLT_ASSERT(a_lid_only_on_ok, (res_valid && (res.lock_id != 4'd0)) |-> (res.status == oflt_pkg::ST_OK), "lock id with failed status")
  `OFLT_ASSERT(a_too_many_only_check, (res_valid && (res.status == oflt_pkg::ST_TOO_MANY)) |-> (req.cmd == oflt_pkg::CMD_CHECK), "too many open outside check")
  `OFLT_ASSERT(a_one_word_at_a_time, (req_valid && req_ready) |=> !req_ready, "second word taken mid command")

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for open_file_lock_table_unit, driven over both handshakes.
// Depends on oflt_pkg and the unit itself. A scoreboard class keeps its own copy of the
// table, predicts each reply word and checks the replies in order.

module tb_top;

  localparam int SLOTS           = 8;
  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_CYCLES     = 400;
  localparam int TAIL_CYCLES     = 40;
  localparam int WORDS_PER_PHASE = 450;
  localparam int POOL_SIZE       = 12;
  localparam int REPORT_MAX      = 10;

  localparam logic [1:0] ACC_WRITE  = 2'd1;
  localparam logic [1:0] ACC_ODD    = 2'd3;
  localparam logic [2:0] CMD_RSVD_5 = 3'd5;
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [3:0]  vol;
    logic [31:0] clu;
    logic [31:0] off;
  } obj_key_t;

  class lock_table_scoreboard;
    bit              held[SLOTS];
    logic [3:0]      vol_of[SLOTS];
    logic [31:0]     clu_of[SLOTS];
    logic [31:0]     off_of[SLOTS];
    logic [8:0]      count_of[SLOTS];
    oflt_pkg::res_t  replies_due[$];
    int              mismatches;
    int              replies_seen;

    function int slot_of_key(oflt_pkg::req_t w);
      for (int k = 0; k < SLOTS; k++)
        if (held[k] && vol_of[k] == w.volume_id && clu_of[k] == w.dir_cluster &&
            off_of[k] == w.dir_offset)
          return k;
      return SLOTS;
    endfunction

    function int first_free();
      for (int k = 0; k < SLOTS; k++)
        if (!held[k]) return k;
      return SLOTS;
    endfunction

    function void note_word(oflt_pkg::req_t w);
      oflt_pkg::res_t r;
      int             k;
      logic [8:0]     n;
      r.status  = oflt_pkg::ST_ERROR;
      r.lock_id = '0;
      case (w.cmd)
        oflt_pkg::CMD_CHECK: begin
          k = slot_of_key(w);
          if (k < SLOTS)
            r.status = (w.access != oflt_pkg::ACC_READ ||
                        count_of[k] == oflt_pkg::WRITE_MARK) ?
                       oflt_pkg::ST_LOCKED : oflt_pkg::ST_OK;
          else
            r.status = (first_free() == SLOTS && w.access != oflt_pkg::ACC_DELETE) ?
                       oflt_pkg::ST_TOO_MANY : oflt_pkg::ST_OK;
        end
        oflt_pkg::CMD_ENQUIRE:
          r.status = (first_free() < SLOTS) ? oflt_pkg::ST_OK : oflt_pkg::ST_LOCKED;
        oflt_pkg::CMD_OPEN: begin
          k = slot_of_key(w);
          if (k == SLOTS) begin
            k = first_free();
            if (k < SLOTS) begin
              held[k]     = 1'b1;
              vol_of[k]   = w.volume_id;
              clu_of[k]   = w.dir_cluster;
              off_of[k]   = w.dir_offset;
              count_of[k] = '0;
            end
          end
          if (k < SLOTS) begin
            // any access other than read needs an unused entry
            if (w.access != oflt_pkg::ACC_READ) begin
              if (count_of[k] == '0) begin
                count_of[k] = oflt_pkg::WRITE_MARK;
                r.status    = oflt_pkg::ST_OK;
              end
            end else if (count_of[k] < oflt_pkg::READ_MAX) begin
              count_of[k] = count_of[k] + 9'd1;
              r.status    = oflt_pkg::ST_OK;
            end
            if (r.status == oflt_pkg::ST_OK) r.lock_id = 4'(k + 1);
          end
        end
        oflt_pkg::CMD_CLOSE: begin
          r.status = oflt_pkg::ST_INT_ERR;
          k = int'(w.close_id) - 1;
          if (k >= 0 && k < SLOTS && held[k]) begin
            n = (count_of[k] == oflt_pkg::WRITE_MARK) ? 9'd0 : count_of[k];
            if (n != '0) n = n - 9'd1;
            count_of[k] = n;
            if (n == '0) held[k] = 1'b0;
            r.status = oflt_pkg::ST_OK;
          end
        end
        oflt_pkg::CMD_CLEAR: begin
          r.status = oflt_pkg::ST_INT_ERR;
          for (k = 0; k < SLOTS; k++)
            if (held[k] && vol_of[k] == w.volume_id) begin
              held[k]  = 1'b0;
              r.status = oflt_pkg::ST_OK;
            end
        end
        default: ;
      endcase
      replies_due.push_back(r);
    endfunction

    function void check_result(oflt_pkg::res_t got);
      oflt_pkg::res_t want;
      replies_seen++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("reply %0d with none due: status %0d lock_id %0d",
                   replies_seen, got.status, got.lock_id);
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status || got.lock_id !== want.lock_id) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("reply %0d: status exp %0d got %0d, lock_id exp %0d got %0d",
                   replies_seen, want.status, got.status, want.lock_id, got.lock_id);
      end
    endfunction

    // random 1-based id of an entry in use, 0 when the table is empty
    function logic [3:0] pick_held_id();
      int ids[$];
      for (int k = 0; k < SLOTS; k++)
        if (held[k]) ids.push_back(k + 1);
      if (ids.size() == 0) return '0;
      return 4'(ids[$urandom_range(ids.size() - 1)]);
    endfunction
  endclass

  logic        clk;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [2:0]  cmd        = '0;
  logic [3:0]  volume_id  = '0;
  logic [31:0] dir_cluster = '0;
  logic [31:0] dir_offset = '0;
  logic [1:0]  access     = '0;
  logic [3:0]  close_id   = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [2:0]  status;
  logic [3:0]  lock_id;

  lock_table_scoreboard sb = new;

  int       tx_idle_pct  = 0;
  int       rx_idle_pct  = 0;
  int       hold_asks    = 0;
  int       hold_taken   = 0;
  int       hold_left    = 0;
  int       quiet_cycles = 0;
  obj_key_t pool[POOL_SIZE];

  open_file_lock_table_unit #(.ENTRIES(SLOTS)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .volume_id  (volume_id),
    .dir_cluster(dir_cluster),
    .dir_offset (dir_offset),
    .access     (access),
    .close_id   (close_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .lock_id    (lock_id)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off when asked for one
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asks != hold_taken) begin
        hold_taken = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_word({cmd, volume_id, dir_cluster, dir_offset, access, close_id});
    if (!rst && out_valid && out_ready)
      sb.check_result({status, lock_id});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("open_file_lock_table_unit verification failed");
      $finish;
    end
  end

  function automatic oflt_pkg::req_t build_word(logic [2:0] c, obj_key_t key, logic [1:0] a,
                                                logic [3:0] id);
    oflt_pkg::req_t w;
    w.cmd         = c;
    w.volume_id   = key.vol;
    w.dir_cluster = key.clu;
    w.dir_offset  = key.off;
    w.access      = a;
    w.close_id    = id;
    return w;
  endfunction

  function automatic obj_key_t fresh_key();
    obj_key_t key;
    key.vol = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
    key.clu = ($urandom_range(7) == 0) ? '0 : $urandom;
    key.off = ($urandom_range(7) == 0) ? '1 : $urandom;
    return key;
  endfunction

  // some keys copy their neighbour and differ in one field only, so the full key compare is exercised
  function automatic void fill_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i > 0 && $urandom_range(2) == 0) begin
        pool[i] = pool[i - 1];
        case ($urandom_range(2))
          0:       pool[i].vol = pool[i].vol ^ 4'($urandom_range(1, 15));
          1:       pool[i].clu = pool[i].clu ^ (32'd1 << $urandom_range(31));
          default: pool[i].off = pool[i].off ^ (32'd1 << $urandom_range(31));
        endcase
      end else begin
        pool[i] = fresh_key();
      end
    end
  endfunction

  function automatic oflt_pkg::req_t random_word();
    obj_key_t   key;
    logic [1:0] acc;
    logic [3:0] id;
    int         pick;
    key  = pool[$urandom_range(POOL_SIZE - 1)];
    acc  = ($urandom_range(9) < 6) ? oflt_pkg::ACC_READ : 2'($urandom_range(1, 3));
    id   = 4'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 40) return build_word(oflt_pkg::CMD_OPEN, key, acc, id);
    if (pick < 65) begin
      if (sb.pick_held_id() != '0) id = sb.pick_held_id();
      return build_word(oflt_pkg::CMD_CLOSE, key, acc, id);
    end
    if (pick < 77) return build_word(oflt_pkg::CMD_CHECK, key, 2'($urandom_range(3)), id);
    if (pick < 82) return build_word(oflt_pkg::CMD_ENQUIRE, key, acc, id);
    if (pick < 87) return build_word(oflt_pkg::CMD_CLEAR, key, acc, id);
    // noise: any command, any field
    key.vol = 4'($urandom_range(15));
    key.clu = $urandom;
    key.off = $urandom;
    return build_word(3'($urandom_range(7)), key, 2'($urandom_range(3)), id);
  endfunction

  task automatic send_word(input oflt_pkg::req_t w);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= w.cmd;
    volume_id   <= w.volume_id;
    dir_cluster <= w.dir_cluster;
    dir_offset  <= w.dir_offset;
    access      <= w.access;
    close_id    <= w.close_id;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    obj_key_t key_a;
    obj_key_t key_b;
    obj_key_t key_n;
    obj_key_t key_s;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 31;
    rx_idle_pct = 60;

    key_a = '{vol: '1, clu: '1, off: '1};
    key_b = '0;
    // empty table, bad close ids, clear of nothing, reserved commands
    send_word(build_word(oflt_pkg::CMD_ENQUIRE, key_a, oflt_pkg::ACC_READ, 4'd0));
    send_word(build_word(oflt_pkg::CMD_CHECK, key_a, oflt_pkg::ACC_READ, 4'd0));
    send_word(build_word(oflt_pkg::CMD_CLOSE, key_a, oflt_pkg::ACC_READ, 4'd0));
    send_word(build_word(oflt_pkg::CMD_CLOSE, key_a, oflt_pkg::ACC_READ, 4'd15));
    send_word(build_word(oflt_pkg::CMD_CLOSE, key_a, oflt_pkg::ACC_READ, 4'd1));
    send_word(build_word(oflt_pkg::CMD_CLEAR, key_a, oflt_pkg::ACC_READ, 4'd0));
    send_word(build_word(CMD_RSVD_5, key_a, oflt_pkg::ACC_READ, 4'd0));
    send_word(build_word(CMD_RSVD_6, key_b, ACC_WRITE, 4'd0));
    send_word(build_word(CMD_RSVD_7, key_a, ACC_ODD, 4'd15));
    // write open blocks reads; odd access behaves as write
    send_word(build_word(oflt_pkg::CMD_OPEN, key_a, ACC_WRITE, 4'd0));
    send_word(build_word(oflt_pkg::CMD_OPEN, key_a, oflt_pkg::ACC_READ, 4'd0));
    send_word(build_word(oflt_pkg::CMD_CHECK, key_a, oflt_pkg::ACC_READ, 4'd0));
    send_word(build_word(oflt_pkg::CMD_OPEN, key_a, ACC_ODD, 4'd0));
    send_word(build_word(oflt_pkg::CMD_OPEN, key_b, oflt_pkg::ACC_READ, 4'd0));
    send_word(build_word(oflt_pkg::CMD_OPEN, key_b, oflt_pkg::ACC_READ, 4'd0));
    send_word(build_word(oflt_pkg::CMD_CHECK, key_b, ACC_WRITE, 4'd0));
    // fill the table, then probe it full
    for (int i = 0; i < SLOTS - 2; i++) begin
      key_n     = fresh_key();
      key_n.vol = 4'd9;
      send_word(build_word(oflt_pkg::CMD_OPEN, key_n, ACC_WRITE, 4'd0));
    end
    key_n     = fresh_key();
    key_n.vol = 4'd5;
    send_word(build_word(oflt_pkg::CMD_ENQUIRE, key_n, oflt_pkg::ACC_READ, 4'd0));
    send_word(build_word(oflt_pkg::CMD_CHECK, key_n, oflt_pkg::ACC_READ, 4'd0));
    send_word(build_word(oflt_pkg::CMD_CHECK, key_n, oflt_pkg::ACC_DELETE, 4'd0));
    send_word(build_word(oflt_pkg::CMD_OPEN, key_n, oflt_pkg::ACC_READ, 4'd0));
    send_word(build_word(oflt_pkg::CMD_CLOSE, key_a, oflt_pkg::ACC_READ, 4'd1));
    send_word(build_word(oflt_pkg::CMD_CLOSE, key_a, oflt_pkg::ACC_READ, 4'd2));
    send_word(build_word(oflt_pkg::CMD_CLOSE, key_a, oflt_pkg::ACC_READ, 4'd2));
    key_n.vol = 4'd9;
    send_word(build_word(oflt_pkg::CMD_CLEAR, key_n, oflt_pkg::ACC_READ, 4'd0));

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 60 : 0;
      rx_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 31 : 0;
      fill_pool();
      if (ph == 2) begin
        // receiver holds off while the sender keeps going
        hold_asks <= hold_asks + 1;
        for (int v = 0; v < 16; v++) begin
          key_n     = fresh_key();
          key_n.vol = 4'(v);
          send_word(build_word(oflt_pkg::CMD_CLEAR, key_n, oflt_pkg::ACC_READ, 4'd0));
        end
        // read count runs up to its ceiling, one more read is refused
        key_s = fresh_key();
        repeat (int'(oflt_pkg::READ_MAX) + 1)
          send_word(build_word(oflt_pkg::CMD_OPEN, key_s, oflt_pkg::ACC_READ, 4'd0));
        send_word(build_word(oflt_pkg::CMD_OPEN, key_s, ACC_WRITE, 4'd0));
        send_word(build_word(oflt_pkg::CMD_CHECK, key_s, oflt_pkg::ACC_READ, 4'd0));
        send_word(build_word(oflt_pkg::CMD_CHECK, key_s, ACC_WRITE, 4'd0));
      end
      repeat (WORDS_PER_PHASE) send_word(random_word());
    end
    in_valid <= 1'b0;

    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.replies_due.size() == 0)
      $display("open_file_lock_table_unit verification clean");
    else
      $display("open_file_lock_table_unit verification failed");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/oflt_pkg.sv
rtl/oflt_entry_ram.sv
rtl/oflt_ctrl.sv
rtl/open_file_lock_table_unit.sv
test/tb_top.sv
